### rtl/assert_macros.svh
// Assertion macros used by the resampler top level; they compile to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/pcmrs_pkg.sv
// Types, codes and helpers shared by the PCM FIFO resampler.
package pcmrs_pkg;

  localparam int APB_ADDR_W = 5;

  localparam logic [2:0] CMD_PUSH_BYTE = 3'd0;
  localparam logic [2:0] CMD_PUSH_HALF = 3'd1;
  localparam logic [2:0] CMD_PUSH_WORD = 3'd2;
  localparam logic [2:0] CMD_TIMER     = 3'd3;
  localparam logic [2:0] CMD_CLEAR     = 3'd4;

  localparam logic [2:0] REG_AUDIO_EN = 3'd0;
  localparam logic [2:0] REG_SOUND_EN = 3'd1;
  localparam logic [2:0] REG_CH0_ROUTE = 3'd2;
  localparam logic [2:0] REG_CH1_ROUTE = 3'd3;
  localparam logic [2:0] REG_CH0_HALF = 3'd4;
  localparam logic [2:0] REG_CH1_HALF = 3'd5;

  localparam logic [23:0] MIN_STEP = 24'd1024;
  localparam int unsigned REFILL_LEVEL = 16;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        channel;
    logic [31:0] push_data;
    logic [23:0] step_size;
  } request_t;

  typedef struct packed {
    logic               out_channel;
    logic [13:0]        buffer_slot;
    logic signed [11:0] left_add;
    logic signed [11:0] right_add;
    logic               sample_valid;
    logic               last;
    logic               refill_request;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_RD_CUR,
    ST_RD_NXT,
    ST_LOAD,
    ST_MUL,
    ST_EMIT,
    ST_CHECK
  } state_t;

  // A FIFO byte as a sample: taken as signed, scaled by 16, zero if not valid and optionally halved.
  function automatic logic signed [11:0] byte_sample(logic [7:0] b, logic vld, logic half);
    logic signed [11:0] s;
    s = vld ? $signed({b, 4'b0000}) : 12'sd0;
    return half ? (s >>> 1) : s;
  endfunction

endpackage

### rtl/pcmrs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module pcmrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/pcm_fifo_interpolating_resampler.sv
// Top level of the two-channel PCM FIFO resampler with linear interpolation.
// Push requests write 1, 2 or 4 FIFO bytes, one byte per cycle; a clear is done in idle.
// A timer request with audio on reads two bytes in ST_RD_CUR, ST_RD_NXT and ST_LOAD, then the
// shared multiplier gives one result per pass through ST_MUL and ST_EMIT: a run of N results,
// N from 1 to 64, each held in ST_EMIT while stalled. Audio off loads a single result from ST_CHECK.
// Reset is synchronous and clears pointers, phase, positions, FIFO valid bits and result_valid.
`include "assert_macros.svh"

module pcm_fifo_interpolating_resampler #(
  parameter int FIFO_DEPTH = 32,
  parameter int OUT_BUFFER_SIZE = 16384
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                request_valid,
  output logic                                request_stall,
  input  pcmrs_pkg::request_t                 request,
  output logic                                result_valid,
  input  logic                                result_stall,
  output pcmrs_pkg::result_t                  result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pcmrs_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  import pcmrs_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int MEM_DEPTH = 2 * FIFO_DEPTH;
  localparam int ADDR_W = $clog2(MEM_DEPTH);
  localparam int POS_W = $clog2(OUT_BUFFER_SIZE);

  // Configuration registers.
  logic       audio_enable;
  logic       sound_enable;
  logic [1:0] route [2];
  logic       half [2];

  // Per-channel FIFO and resampler state.
  logic [PTR_W-1:0]      wp [2];
  logic [PTR_W-1:0]      rp [2];
  logic [15:0]           phase [2];
  logic [POS_W-1:0]      pos [2];
  logic [FIFO_DEPTH-1:0] fifo_vld [2];

  // Sequencer and working registers of the request in progress.
  state_t             state, state_next;
  logic [1:0]         push_cnt;
  logic               ch;
  logic [31:0]        data;
  logic [23:0]        step;
  logic               cur_vld, nxt_vld;
  logic signed [11:0] cur, nxt;
  logic [15:0]        frac;
  logic [POS_W-1:0]   opos;
  logic signed [29:0] prod;

  logic               accept;
  logic               out_free;
  logic               out_load;
  logic               cfg_write;
  logic [2:0]         reg_idx;
  logic [23:0]        step_sat;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [7:0]         rd_data;
  logic signed [12:0] diff;
  logic signed [16:0] frac_s;
  logic signed [29:0] prod_next;
  logic signed [13:0] delta, val_wide;
  logic signed [11:0] val;
  logic [24:0]        frac_sum;
  logic               run_done;
  logic [POS_W:0]     pos_sum;
  logic [POS_W-1:0]   pos_adv;
  logic [PTR_W:0]     fill_diff, fill;
  logic               refill_now;
  result_t            result_next;

  // Conditions watched by the assertions at the end.
  logic               timer_go;
  logic               emit_go;
  logic               check_go;
  logic               ptrs_ok;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Channel 1 occupies the upper half of the shared byte memory.
  function automatic logic [ADDR_W-1:0] fifo_addr(logic c, logic [PTR_W-1:0] p);
    return c ? ADDR_W'(FIFO_DEPTH) + ADDR_W'(p) : ADDR_W'(p);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port. Registers sit at word addresses; pready is tied high,
  // so every access completes in its access cycle.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      audio_enable <= 1'b1;
      sound_enable <= 1'b0;
      route[0] <= 2'd0;
      route[1] <= 2'd0;
      half[0] <= 1'b0;
      half[1] <= 1'b0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_AUDIO_EN: audio_enable <= pwdata[0];
        REG_SOUND_EN: sound_enable <= pwdata[0];
        REG_CH0_ROUTE: route[0] <= pwdata[1:0];
        REG_CH1_ROUTE: route[1] <= pwdata[1:0];
        REG_CH0_HALF: half[0] <= pwdata[0];
        REG_CH1_HALF: half[1] <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_AUDIO_EN: prdata = {31'd0, audio_enable};
      REG_SOUND_EN: prdata = {31'd0, sound_enable};
      REG_CH0_ROUTE: prdata = {30'd0, route[0]};
      REG_CH1_ROUTE: prdata = {30'd0, route[1]};
      REG_CH0_HALF: prdata = {31'd0, half[0]};
      REG_CH1_HALF: prdata = {31'd0, half[1]};
      default: prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // FIFO byte storage. Both channels share one memory; writes come from push
  // requests and reads from the two-byte fetch of a timer request, never in
  // the same cycle. Entries not written since reset or the last clear are
  // masked to zero through the per-entry valid bits.
  // ---------------------------------------------------------------------------
  assign mem_waddr = fifo_addr(ch, wp[ch]);
  assign mem_raddr = fifo_addr(ch, rp[ch]);

  pcmrs_ram #(
    .WIDTH(8),
    .DEPTH(MEM_DEPTH)
  ) u_fifo_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(data[7:0]),
    .raddr(mem_raddr),
    .rdata(rd_data)
  );

  // ---------------------------------------------------------------------------
  // Shared datapath: one signed multiplier for the interpolation, then the add
  // of the current sample and the phase and position updates.
  // ---------------------------------------------------------------------------
  assign step_sat = (request.step_size < MIN_STEP) ? MIN_STEP : request.step_size;

  assign diff = $signed({nxt[11], nxt}) - $signed({cur[11], cur});
  assign frac_s = $signed({1'b0, frac});
  assign prod_next = diff * frac_s;

  // The arithmetic shift of the product floors the scaled difference.
  assign delta = $signed(prod[29:16]);
  assign val_wide = $signed({{2{cur[11]}}, cur}) + delta;
  assign val = $signed(val_wide[11:0]);

  // The run ends once the phase reaches one whole sample.
  assign frac_sum = {9'd0, frac} + {1'b0, step};
  assign run_done = |frac_sum[24:16];

  assign pos_sum = {1'b0, opos} + (POS_W+1)'(2);
  assign pos_adv = (pos_sum >= (POS_W+1)'(OUT_BUFFER_SIZE))
                 ? POS_W'(pos_sum - (POS_W+1)'(OUT_BUFFER_SIZE))
                 : pos_sum[POS_W-1:0];

  // FIFO fill level of the active channel. During a run the read pointer has
  // already moved past the popped byte, so this is the level after the pop.
  assign fill_diff = {1'b0, wp[ch]} - {1'b0, rp[ch]};
  assign fill = fill_diff[PTR_W] ? fill_diff + (PTR_W+1)'(FIFO_DEPTH) : fill_diff;
  assign refill_now = (32'(fill) <= REFILL_LEVEL);

  // ---------------------------------------------------------------------------
  // Sequencer. A request is taken only in idle; a push or timer request then walks its own
  // path of states and returns to idle when its last byte is written or its last result is loaded.
  // ---------------------------------------------------------------------------
  assign request_stall = (state != ST_IDLE);
  assign accept = request_valid && !request_stall;
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (request.cmd)
            CMD_PUSH_BYTE, CMD_PUSH_HALF, CMD_PUSH_WORD: state_next = ST_PUSH;
            CMD_TIMER: state_next = audio_enable ? ST_RD_CUR : ST_CHECK;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_PUSH: begin
        mem_we = 1'b1;
        if (push_cnt == 2'd0) begin
          state_next = ST_IDLE;
        end
      end
      ST_RD_CUR: state_next = ST_RD_NXT;
      ST_RD_NXT: state_next = ST_LOAD;
      ST_LOAD: state_next = ST_MUL;
      ST_MUL: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_next = run_done ? ST_IDLE : ST_MUL;
        end
      end
      ST_CHECK: begin
        if (out_free) begin
          out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Pointers, phase, positions and valid bits of both channels.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp[0] <= '0;
      wp[1] <= '0;
      rp[0] <= '0;
      rp[1] <= '0;
      phase[0] <= '0;
      phase[1] <= '0;
      pos[0] <= '0;
      pos[1] <= '0;
      fifo_vld[0] <= '0;
      fifo_vld[1] <= '0;
      push_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (request.cmd)
              CMD_PUSH_BYTE: push_cnt <= 2'd0;
              CMD_PUSH_HALF: push_cnt <= 2'd1;
              CMD_PUSH_WORD: push_cnt <= 2'd3;
              // Clearing only drops the valid bits; the pointers stay put.
              CMD_CLEAR: fifo_vld[request.channel] <= '0;
              default: ;
            endcase
          end
        end
        ST_PUSH: begin
          // Writes wrap and may overwrite bytes that were never read.
          fifo_vld[ch][wp[ch]] <= 1'b1;
          wp[ch] <= ptr_inc(wp[ch]);
          push_cnt <= push_cnt - 2'd1;
        end
        ST_RD_CUR: begin
          rp[ch] <= ptr_inc(rp[ch]);
        end
        ST_EMIT: begin
          if (out_load && run_done) begin
            phase[ch] <= frac_sum[15:0];
            pos[ch] <= pos_adv;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers of the request in progress.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          ch <= request.channel;
          data <= request.push_data;
          step <= step_sat;
        end
      end
      ST_PUSH: begin
        data <= data >> 8;
      end
      ST_RD_CUR: begin
        cur_vld <= fifo_vld[ch][rp[ch]];
        frac <= phase[ch];
        opos <= pos[ch];
      end
      ST_RD_NXT: begin
        cur <= byte_sample(rd_data, cur_vld, half[ch]);
        nxt_vld <= fifo_vld[ch][rp[ch]];
      end
      ST_LOAD: begin
        nxt <= byte_sample(rd_data, nxt_vld, half[ch]);
      end
      ST_MUL: begin
        prod <= prod_next;
      end
      ST_EMIT: begin
        if (out_load) begin
          frac <= frac_sum[15:0];
          opos <= pos_adv;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result register. It holds one finished result until the receiver takes it,
  // and the sequencer waits in its emit or check state while it is occupied and stalled.
  // ---------------------------------------------------------------------------
  always_comb begin
    result_next.out_channel = ch;
    if (state == ST_CHECK) begin
      // Audio off: no pop and no rendering, only the refill check.
      result_next.buffer_slot = 14'(pos[ch]);
      result_next.left_add = '0;
      result_next.right_add = '0;
      result_next.sample_valid = 1'b0;
      result_next.last = 1'b1;
      result_next.refill_request = refill_now;
    end else begin
      result_next.buffer_slot = 14'(opos);
      result_next.left_add = (sound_enable && route[ch][1]) ? val : '0;
      result_next.right_add = (sound_enable && route[ch][0]) ? val : '0;
      result_next.sample_valid = 1'b1;
      result_next.last = run_done;
      result_next.refill_request = run_done && refill_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= result_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  assign timer_go = accept && (request.cmd == CMD_TIMER) && audio_enable;
  assign emit_go = (state == ST_EMIT) && out_free;
  assign check_go = (state == ST_CHECK) && out_free;
  assign ptrs_ok = (32'(wp[0]) < FIFO_DEPTH) && (32'(wp[1]) < FIFO_DEPTH)
                && (32'(rp[0]) < FIFO_DEPTH) && (32'(rp[1]) < FIFO_DEPTH);

  `ASSERT_IMPL(a_mid_run_is_sample, clk, rst, result_valid && !result.last, result.sample_valid)
  `ASSERT_NEXT(a_timer_starts_fetch, clk, rst, timer_go, state == ST_RD_CUR)
  `ASSERT_NEXT(a_emit_loads_sample, clk, rst, emit_go, result_valid && result.sample_valid)
  `ASSERT_NEXT(a_check_last, clk, rst, check_go, result_valid && result.last && !result.sample_valid)
  `ASSERT_IMPL(a_ptr_in_range, clk, rst, 1'b1, ptrs_ok)

endmodule
